// ===== hw/rtl/vurp_pkg.sv =====
package vurp_pkg;

  // name-table store geometry
  localparam int NT_BYTES = 2048;
  localparam int NT_AW    = $clog2(NT_BYTES);

  // scanline events
  localparam logic [8:0] LAST_LINE   = 9'(261);
  localparam logic [8:0] VBLANK_LINE = 9'(241);
  localparam logic [8:0] HIT_LINE    = 9'(32);

  // video address map
  localparam logic [15:0] NT_BASE   = 16'h2000;
  localparam logic [15:0] NT_END    = 16'h3000;
  localparam logic [15:0] PAL_BASE  = 16'h3f00;
  localparam logic [15:0] ADDR_MASK = 16'h3fff;

  // sprite-zero hit test
  localparam logic [7:0] HIT_ROW_LIMIT = 8'hef;
  localparam logic [7:0] HIT_TILE      = 8'hff;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_REG  = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_PAT_READ = 2'd3
  } status_code_t;

  // register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // control and status bits
  localparam int CTRL_INC32_BIT = 2;
  localparam int STAT_HIT_BIT   = 6;
  localparam int STAT_VBL_BIT   = 7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_index;
    logic [7:0] write_value;
    logic [7:0] sprite_zero_row;
    logic [7:0] sprite_zero_tile;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  status_code;
    logic [15:0] scroll_value;
    logic [8:0]  line_number;
  } result_t;

  // name-table access from the register core
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [NT_AW-1:0] addr;
    logic [7:0]       wdata;
  } nt_req_t;

endpackage

// ===== hw/rtl/video_unit_register_port_top.sv =====
// an accepted input beat reaches its result beat through the input register, then the
// result register
// throughput: one beat per cycle unless stalled; a beat makes at most one name-table access
// reset: rst_n synchronous active low clears all register state, then a sweep zeroes the
// name-table store one byte per cycle (NT_BYTES bytes, 2048 by default); in_tready stays low
// until the sweep is done
module video_unit_register_port_top
  import vurp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // reg_index, write_value, sprite_zero_row, sprite_zero_tile
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_data, scroll_value, line_number
  output logic [1:0]  out_tuser   // status_code
);

  logic      in_valid_r;
  item_t     in_item_r;
  logic      out_valid_r;
  result_t   out_res_r;
  logic      advance;
  logic      nt_busy;
  logic      in_fire;
  nt_req_t   nt_req;
  logic [7:0] nt_q;
  result_t   result;

  // core runs when the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  // input register takes a new beat whenever its current one moves on
  assign in_tready = !nt_busy && (!in_valid_r || advance);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.req_type         <= in_tuser;
      in_item_r.reg_index        <= in_tdata[2:0];
      in_item_r.write_value      <= in_tdata[10:3];
      in_item_r.sprite_zero_row  <= in_tdata[18:11];
      in_item_r.sprite_zero_tile <= in_tdata[26:19];
    end
  end

  vurp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .nt_q   (nt_q),
    .nt_req (nt_req),
    .result (result)
  );

  vurp_nt_mem u_nt_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nt_req),
    .busy  (nt_busy),
    .rd_q  (nt_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.line_number, out_res_r.scroll_value,
                       out_res_r.read_data};
  assign out_tuser  = out_res_r.status_code;

endmodule

// ===== hw/rtl/vurp_nt_mem.sv =====
module vurp_nt_mem
  import vurp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  nt_req_t req,
  output logic    busy,
  output logic [7:0] rd_q
);

  localparam logic [NT_AW:0] NT_DEPTH = (NT_AW + 1)'(NT_BYTES);

  logic [7:0]       mem [NT_BYTES];
  logic [NT_AW:0]   clr_cnt_r;
  logic [NT_AW:0]   clr_cnt_nxt;
  logic             we;
  logic [NT_AW-1:0] waddr;
  logic [7:0]       wdata;

  // clearing sweep runs once after reset
  assign busy        = (clr_cnt_r != NT_DEPTH);
  assign clr_cnt_nxt = busy ? clr_cnt_r + 1'b1 : clr_cnt_r;

  assign we    = busy | req.wr_en;
  assign waddr = busy ? clr_cnt_r[NT_AW-1:0] : req.addr;
  assign wdata = busy ? 8'h00 : req.wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q <= mem[req.addr];
    end
  end

endmodule

// ===== hw/rtl/vurp_core.sv =====
module vurp_core
  import vurp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  item_t      item,
  input  logic [7:0] nt_q,
  output nt_req_t    nt_req,
  output result_t    result
);

  localparam logic [12:0] NT_LIMIT = 13'(NT_BYTES);

  logic [7:0]  status_r, status_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic        latch_r, latch_nxt;
  logic [15:0] scroll_r, scroll_nxt;
  logic [15:0] vaddr_r, vaddr_nxt;
  logic [7:0]  rbuf_r, rbuf_nxt;
  logic        rbuf_mem_r, rbuf_mem_nxt;
  logic [8:0]  line_r, line_nxt;

  logic [7:0]  rbuf_eff;
  logic [15:0] vaddr_step;
  logic [11:0] nt_off;
  logic        in_nt;
  logic        nt_ok;
  logic        in_pal;
  logic [7:0]  rdata;
  logic [1:0]  code;

  // buffer refill lands in the memory's read register
  assign rbuf_eff   = rbuf_mem_r ? nt_q : rbuf_r;
  assign vaddr_step = vaddr_r + (ctrl_r[CTRL_INC32_BIT] ? 16'd32 : 16'd1);
  assign nt_off     = vaddr_r[11:0];
  assign in_nt      = (vaddr_r >= NT_BASE) && (vaddr_r < NT_END);
  assign nt_ok      = in_nt && ({1'b0, nt_off} < NT_LIMIT);
  assign in_pal     = (vaddr_r >= PAL_BASE);

  always_comb begin
    status_nxt   = status_r;
    ctrl_nxt     = ctrl_r;
    latch_nxt    = latch_r;
    scroll_nxt   = scroll_r;
    vaddr_nxt    = vaddr_r;
    rbuf_nxt     = rbuf_r;
    rbuf_mem_nxt = rbuf_mem_r;
    line_nxt     = line_r;
    rdata        = 8'h00;
    code         = ST_OK;
    nt_req.rd_en = 1'b0;
    nt_req.wr_en = 1'b0;
    nt_req.addr  = nt_off[NT_AW-1:0];
    nt_req.wdata = item.write_value;

    case (item.req_type)
      REQ_READ: begin
        case (item.reg_index)
          REG_STATUS: begin
            rdata                    = status_r;
            status_nxt[STAT_VBL_BIT] = 1'b0;
            latch_nxt                = 1'b0;
          end
          REG_DATA: begin
            if (vaddr_r < NT_BASE) begin
              code = ST_PAT_READ;
            end else if (!nt_ok) begin
              code = ST_BAD_ADDR;
            end else begin
              rdata        = rbuf_eff;
              rbuf_nxt     = rbuf_eff;
              rbuf_mem_nxt = 1'b1;
              nt_req.rd_en = fire;
              vaddr_nxt    = vaddr_step;
            end
          end
          default: code = ST_BAD_REG;
        endcase
      end
      REQ_WRITE: begin
        case (item.reg_index)
          REG_CTRL: ctrl_nxt = item.write_value;
          REG_MASK, REG_OAM_ADDR: ;
          REG_SCROLL: begin
            if (!latch_r) begin
              scroll_nxt = {item.write_value, 8'h00};
            end else begin
              scroll_nxt = scroll_r | {8'h00, item.write_value};
            end
            latch_nxt = !latch_r;
          end
          REG_ADDR: begin
            if (!latch_r) begin
              vaddr_nxt = {item.write_value, 8'h00};
            end else begin
              vaddr_nxt = (vaddr_r | {8'h00, item.write_value}) & ADDR_MASK;
            end
            latch_nxt = !latch_r;
          end
          REG_DATA: begin
            // palette entries cannot be read back through this port
            if (nt_ok || (!in_nt && in_pal)) begin
              nt_req.wr_en = fire && nt_ok;
              rbuf_nxt     = item.write_value;
              rbuf_mem_nxt = 1'b0;
              vaddr_nxt    = vaddr_step;
            end else begin
              code = ST_BAD_ADDR;
            end
          end
          default: code = ST_BAD_REG;
        endcase
      end
      REQ_TICK: begin
        line_nxt = (line_r >= LAST_LINE) ? 9'd0 : line_r + 9'd1;
        if (line_nxt == HIT_LINE) begin
          if ((item.sprite_zero_row < HIT_ROW_LIMIT) && (item.sprite_zero_tile == HIT_TILE)) begin
            status_nxt[STAT_HIT_BIT] = 1'b1;
          end
        end else if (line_nxt == VBLANK_LINE) begin
          status_nxt[STAT_VBL_BIT] = 1'b1;
        end else if (line_nxt == LAST_LINE) begin
          status_nxt[STAT_VBL_BIT] = 1'b0;
          status_nxt[STAT_HIT_BIT] = 1'b0;
        end
      end
      default: code = ST_BAD_REG;
    endcase
  end

  assign result.read_data    = rdata;
  assign result.status_code  = code;
  assign result.scroll_value = scroll_nxt;
  assign result.line_number  = line_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= '0;
      ctrl_r     <= '0;
      latch_r    <= 1'b0;
      scroll_r   <= '0;
      vaddr_r    <= '0;
      rbuf_r     <= '0;
      rbuf_mem_r <= 1'b0;
      line_r     <= '0;
    end else if (fire) begin
      status_r   <= status_nxt;
      ctrl_r     <= ctrl_nxt;
      latch_r    <= latch_nxt;
      scroll_r   <= scroll_nxt;
      vaddr_r    <= vaddr_nxt;
      rbuf_r     <= rbuf_nxt;
      rbuf_mem_r <= rbuf_mem_nxt;
      line_r     <= line_nxt;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import vurp_pkg::*;

  // req_type value with no request behind it, answered as a bad register
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // register number that the port does not decode
  localparam logic [2:0] REG_NONE   = 3'd4;

  localparam int RANDOM_BEATS = 1950;  // stop point of the random part
  localparam int TAIL_BEATS   = 120;   // last stretch runs without idling
  localparam int DRAIN_CYCLES = 10;    // slack after the last response
  localparam int REPORT_LIMIT = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // reg_index, write_value, sprite_zero_row, sprite_zero_tile
  logic [1:0]  in_tuser   = '0;   // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // read_data, scroll_value, line_number
  logic [1:0]  out_tuser;         // status_code

  video_unit_register_port_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // shadow copy of the register port state, advanced once per accepted beat
  // --------------------------------------------------------------------------
  logic [7:0]  flags_sh;
  logic [7:0]  ctrl_sh;
  logic        latch_sh;      // second write of a scroll/address pair pending
  logic [15:0] scroll_sh;
  logic [15:0] vaddr_sh;
  logic [7:0]  rbuf_sh;
  logic [8:0]  line_sh;
  logic [7:0]  nt_sh  [NT_BYTES];
  logic [7:0]  pal_sh [32];

  item_t   pending_beats[$];        // beats waiting to go onto the input bus
  result_t expected_responses[$];   // predicted response beats, oldest first
  item_t   beat_on_bus;
  bit      random_loaded = 1'b0;
  int      error_count   = 0;
  int      send_gap      = 0;
  int      recv_stall    = 0;

  // applies one request to the shadow state and returns the response it gives
  function automatic result_t port_response(item_t it);
    result_t     r;
    logic [15:0] step;
    logic [15:0] offs;
    logic [4:0]  pidx;
    r = '0;
    r.status_code = ST_OK;
    step = ctrl_sh[CTRL_INC32_BIT] ? 16'd32 : 16'd1;
    offs = vaddr_sh - NT_BASE;
    pidx = 5'(vaddr_sh - PAL_BASE);
    case (it.req_type)
      REQ_READ: begin
        if (it.reg_index == REG_STATUS) begin
          // status read drops vblank and resets the write pair
          r.read_data = flags_sh;
          flags_sh[STAT_VBL_BIT] = 1'b0;
          latch_sh = 1'b0;
        end else if (it.reg_index == REG_DATA) begin
          if (vaddr_sh < NT_BASE) begin
            r.status_code = ST_PAT_READ;
          end else if (vaddr_sh >= NT_END || offs >= NT_BYTES) begin
            // palette and beyond-table reads are refused
            r.status_code = ST_BAD_ADDR;
          end else begin
            // buffered read: old buffer out, table byte in
            r.read_data = rbuf_sh;
            rbuf_sh = nt_sh[offs[NT_AW-1:0]];
            vaddr_sh = vaddr_sh + step;
          end
        end else begin
          r.status_code = ST_BAD_REG;
        end
      end
      REQ_WRITE: begin
        case (it.reg_index)
          REG_CTRL: ctrl_sh = it.write_value;
          REG_MASK, REG_OAM_ADDR: ;  // accepted, nothing kept
          REG_SCROLL: begin
            if (!latch_sh) scroll_sh = {it.write_value, 8'h00};
            else scroll_sh = scroll_sh | {8'h00, it.write_value};
            latch_sh = !latch_sh;
          end
          REG_ADDR: begin
            if (!latch_sh) vaddr_sh = {it.write_value, 8'h00};
            else vaddr_sh = (vaddr_sh | {8'h00, it.write_value}) & ADDR_MASK;
            latch_sh = !latch_sh;
          end
          REG_DATA: begin
            if (vaddr_sh >= NT_BASE && vaddr_sh < NT_END && offs < NT_BYTES) begin
              nt_sh[offs[NT_AW-1:0]] = it.write_value;
              rbuf_sh = it.write_value;
              vaddr_sh = vaddr_sh + step;
            end else if (vaddr_sh >= PAL_BASE) begin
              // sprite backdrop entries fold onto the background ones
              if (pidx[4] && pidx[1:0] == 2'b00) pidx[4] = 1'b0;
              pal_sh[pidx] = it.write_value;
              rbuf_sh = it.write_value;
              vaddr_sh = vaddr_sh + step;
            end else begin
              r.status_code = ST_BAD_ADDR;
            end
          end
          default: r.status_code = ST_BAD_REG;
        endcase
      end
      REQ_TICK: begin
        line_sh = (line_sh >= LAST_LINE) ? 9'd0 : line_sh + 9'd1;
        if (line_sh == HIT_LINE) begin
          if (it.sprite_zero_row < HIT_ROW_LIMIT && it.sprite_zero_tile == HIT_TILE)
            flags_sh[STAT_HIT_BIT] = 1'b1;
        end else if (line_sh == VBLANK_LINE) begin
          flags_sh[STAT_VBL_BIT] = 1'b1;
        end else if (line_sh == LAST_LINE) begin
          flags_sh[STAT_HIT_BIT] = 1'b0;
          flags_sh[STAT_VBL_BIT] = 1'b0;
        end
      end
      default: r.status_code = ST_BAD_REG;
    endcase
    r.scroll_value = scroll_sh;
    r.line_number  = line_sh;
    return r;
  endfunction

  task automatic queue_beat(input logic [1:0] req, input logic [2:0] idx,
                            input logic [7:0] val = 8'h00, input logic [7:0] row = 8'h00,
                            input logic [7:0] tile = 8'h00);
    item_t it;
    it.req_type         = req;
    it.reg_index        = idx;
    it.write_value      = val;
    it.sprite_zero_row  = row;
    it.sprite_zero_tile = tile;
    pending_beats.push_back(it);
  endtask

  // no idling once the random part is nearly through
  function automatic bit tail_part();
    return random_loaded && pending_beats.size() < TAIL_BEATS;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // request driver: presents queued beats, predicts each one as it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_responses.push_back(port_response(beat_on_bus));
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!tail_part() && $urandom_range(0, 11) == 0) begin
          // start an idle burst, this one included; send_gap holds the rest of it
          send_gap  <= $urandom_range(0, 14);
          in_tvalid <= 1'b0;
        end else begin
          beat_on_bus = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, beat_on_bus.sprite_zero_tile, beat_on_bus.sprite_zero_row,
                        beat_on_bus.write_value, beat_on_bus.reg_index};
          in_tuser  <= beat_on_bus.req_type;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // response monitor: stalls in bursts, checks each beat against the oldest
  // prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_data    = out_tdata[7:0];
        got.scroll_value = out_tdata[23:8];
        got.line_number  = out_tdata[32:24];
        got.status_code  = out_tuser;
        if (expected_responses.size() == 0) begin
          flag_error($sformatf({"response beat with nothing predicted: ",
                                "data %h status %0d scroll %h line %0d"},
                               got.read_data, got.status_code, got.scroll_value,
                               got.line_number));
        end else begin
          want = expected_responses.pop_front();
          if (got.read_data !== want.read_data || got.status_code !== want.status_code ||
              got.scroll_value !== want.scroll_value || got.line_number !== want.line_number)
            flag_error($sformatf({"response mismatch: expected data %h status %0d scroll %h ",
                                  "line %0d, got data %h status %0d scroll %h line %0d"},
                                 want.read_data, want.status_code, want.scroll_value,
                                 want.line_number, got.read_data, got.status_code,
                                 got.scroll_value, got.line_number));
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= 1'b0;
      end else if (!tail_part() && $urandom_range(0, 11) == 0) begin
        recv_stall <= $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int         kind;
    int         n;
    int         sel;
    logic [7:0] hi;

    flags_sh  = '0;
    ctrl_sh   = '0;
    latch_sh  = 1'b0;
    scroll_sh = '0;
    vaddr_sh  = '0;
    rbuf_sh   = '0;
    line_sh   = '0;
    for (int i = 0; i < NT_BYTES; i++) nt_sh[i] = '0;
    for (int i = 0; i < 32; i++) pal_sh[i] = '0;

    // directed part
    queue_beat(REQ_READ, REG_STATUS);                   // flags straight after reset
    queue_beat(REQ_WRITE, REG_NONE, 8'ha5);             // undecoded register write
    queue_beat(REQ_READ, REG_CTRL);                     // write-only register read
    queue_beat(REQ_UNUSED, 3'h7, 8'hff, 8'hff, 8'hff);  // unused request type
    queue_beat(REQ_READ, REG_DATA);                     // address 0: pattern area
    queue_beat(REQ_WRITE, REG_DATA, 8'h12);             // pattern area write refused
    queue_beat(REQ_WRITE, REG_SCROLL, 8'hff);           // scroll high then low
    queue_beat(REQ_WRITE, REG_SCROLL, 8'h00);
    queue_beat(REQ_WRITE, REG_ADDR, 8'h27);             // last name-table byte
    queue_beat(REQ_WRITE, REG_ADDR, 8'hff);
    queue_beat(REQ_WRITE, REG_DATA, 8'h55);
    queue_beat(REQ_WRITE, REG_DATA, 8'h66);             // one past the table
    queue_beat(REQ_READ, REG_DATA);
    queue_beat(REQ_WRITE, REG_CTRL, 8'h04);             // step by 32
    queue_beat(REQ_WRITE, REG_ADDR, 8'hff);             // half-written address 0xff00
    queue_beat(REQ_WRITE, REG_DATA, 8'haa);             // palette write with pair pending
    queue_beat(REQ_READ, REG_STATUS);                   // status read drops the pair
    queue_beat(REQ_WRITE, REG_ADDR, 8'h3f);
    queue_beat(REQ_WRITE, REG_ADDR, 8'hf0);             // backdrop mirror entry
    queue_beat(REQ_WRITE, REG_DATA, 8'h81);
    queue_beat(REQ_WRITE, REG_CTRL, 8'h00);
    queue_beat(REQ_WRITE, REG_ADDR, 8'h20);
    queue_beat(REQ_WRITE, REG_ADDR, 8'h00);
    queue_beat(REQ_READ, REG_DATA);                     // buffered reads
    queue_beat(REQ_READ, REG_DATA);
    queue_beat(REQ_TICK, REG_CTRL, 8'h00, 8'hee, 8'hff);
    queue_beat(REQ_TICK, REG_DATA, 8'hff, 8'hff, 8'h00);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // hold off until the directed part has fully drained
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_tvalid || expected_responses.size() != 0);

    // random part: mostly well-formed register sequences and runs of ticks
    while (pending_beats.size() < RANDOM_BEATS) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // run of scanline ticks, so frames wrap several times
        n = $urandom_range(1, 40);
        repeat (n)
          queue_beat(REQ_TICK, 3'($urandom), 8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hef, 8'hff))
                                                 : 8'($urandom),
                     $urandom_range(0, 1) ? HIT_TILE : 8'($urandom));
      end else if (kind < 70) begin
        // address setup then a burst of data accesses
        sel = $urandom_range(0, 19);
        if (sel < 12) hi = 8'($urandom_range(8'h20, 8'h27));
        else if (sel < 14) hi = 8'($urandom_range(8'h28, 8'h2f));
        else if (sel < 16) hi = 8'($urandom_range(8'h00, 8'h1f));
        else if (sel < 18) hi = 8'h3f;
        else hi = 8'($urandom_range(8'h30, 8'hff));
        if ($urandom_range(0, 2) == 0) queue_beat(REQ_WRITE, REG_CTRL, 8'($urandom));
        queue_beat(REQ_WRITE, REG_ADDR, hi);
        // sometimes only the high byte goes in
        if ($urandom_range(0, 7) != 0) queue_beat(REQ_WRITE, REG_ADDR, 8'($urandom));
        n = $urandom_range(1, 12);
        repeat (n)
          queue_beat($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, REG_DATA, 8'($urandom));
      end else if (kind < 78) begin
        queue_beat(REQ_WRITE, REG_SCROLL, 8'($urandom));
        if ($urandom_range(0, 5) != 0) queue_beat(REQ_WRITE, REG_SCROLL, 8'($urandom));
      end else if (kind < 88) begin
        queue_beat(REQ_READ, REG_STATUS, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (kind < 93) begin
        sel = $urandom_range(0, 2);
        queue_beat(REQ_WRITE, (sel == 0) ? REG_CTRL : (sel == 1) ? REG_MASK : REG_OAM_ADDR,
                   8'($urandom));
      end else begin
        // noise: any field value at all
        queue_beat(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
      end
    end
    random_loaded = 1'b1;

    do @(negedge clk);
    while (pending_beats.size() != 0 || in_tvalid || expected_responses.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest legal run including the clearing sweep
  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
